FILE: src/wpg_pkg.sv
// wpg_pkg: shared widths, register indexes, reset values, the gain/threshold
// register struct and the command saturation function for the waypoint guidance block
// no dependencies
`default_nettype none

package wpg_pkg;

	localparam int DEFAULT_COORD_BITS     = 33;
	localparam int DEFAULT_GAIN_FRAC_BITS = 8;

	localparam int GAIN_W   = 12;
	localparam int DIST_W   = 62;
	localparam int VEL_W    = 16;
	localparam int HEIGHT_W = 21;
	localparam int THRUST_W = 22;
	localparam int CMD_W    = 32;
	localparam int SQ_W     = 2 * CMD_W;

	// signed gain times saturated error plus signed gain times velocity
	localparam int SUM_W     = GAIN_W + 1 + CMD_W + 1;
	// room for negation and the rounding offset
	localparam int CMD_PRE_W = SUM_W + 2;

	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_WAYPOINT_LAT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WAYPOINT_LON     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FAR_KP           = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FAR_KD           = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NEAR_KP          = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NEAR_KD          = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_APPROACH_DIST_SQ = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_DIST_SQ   = 3'd7;

	localparam logic [GAIN_W-1:0] RST_FAR_KP  = 12'd256;
	localparam logic [GAIN_W-1:0] RST_FAR_KD  = 12'd128;
	localparam logic [GAIN_W-1:0] RST_NEAR_KP = 12'd512;
	localparam logic [GAIN_W-1:0] RST_NEAR_KD = 12'd128;
	localparam logic [DIST_W-1:0] RST_APPROACH_DIST_SQ = 62'd250000;
	localparam logic [DIST_W-1:0] RST_ARRIVE_DIST_SQ   = 62'd1111;

	typedef struct packed {
		logic [GAIN_W-1:0] far_kp;
		logic [GAIN_W-1:0] far_kd;
		logic [GAIN_W-1:0] near_kp;
		logic [GAIN_W-1:0] near_kd;
		logic [DIST_W-1:0] approach_dist_sq;
		logic [DIST_W-1:0] arrive_dist_sq;
	} gain_cfg_t;

	localparam logic signed [CMD_PRE_W-1:0] CMD_HI =
		{{(CMD_PRE_W-CMD_W+1){1'b0}}, {(CMD_W-1){1'b1}}};
	localparam logic signed [CMD_PRE_W-1:0] CMD_LO = ~CMD_HI;

	function automatic logic signed [CMD_W-1:0] sat_cmd(input logic signed [CMD_PRE_W-1:0] x);
		logic signed [CMD_W-1:0] r;
		if (x > CMD_HI) begin
			r = CMD_HI[CMD_W-1:0];
		end else if (x < CMD_LO) begin
			r = CMD_LO[CMD_W-1:0];
		end else begin
			r = x[CMD_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: src/wpg_cfg_regs.sv
// wpg_cfg_regs: configuration register file (waypoint, gains, thresholds)
// depends on wpg_pkg
`default_nettype none

module wpg_cfg_regs #(
	parameter int COORD_BITS = wpg_pkg::DEFAULT_COORD_BITS,
	parameter int DATA_W     = wpg_pkg::DIST_W
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [wpg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [DATA_W-1:0]                cfg_data,
	output logic signed [COORD_BITS-2:0]          waypoint_lat,
	output logic signed [COORD_BITS-1:0]          waypoint_lon,
	output wpg_pkg::gain_cfg_t                    gains
);
	import wpg_pkg::*;

	logic signed [COORD_BITS-2:0] waypoint_lat_q;
	logic signed [COORD_BITS-1:0] waypoint_lon_q;
	gain_cfg_t                    gains_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waypoint_lat_q           <= '0;
			waypoint_lon_q           <= '0;
			gains_q.far_kp           <= RST_FAR_KP;
			gains_q.far_kd           <= RST_FAR_KD;
			gains_q.near_kp          <= RST_NEAR_KP;
			gains_q.near_kd          <= RST_NEAR_KD;
			gains_q.approach_dist_sq <= RST_APPROACH_DIST_SQ;
			gains_q.arrive_dist_sq   <= RST_ARRIVE_DIST_SQ;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WAYPOINT_LAT:     waypoint_lat_q           <= cfg_data[COORD_BITS-2:0];
				REG_WAYPOINT_LON:     waypoint_lon_q           <= cfg_data[COORD_BITS-1:0];
				REG_FAR_KP:           gains_q.far_kp           <= cfg_data[GAIN_W-1:0];
				REG_FAR_KD:           gains_q.far_kd           <= cfg_data[GAIN_W-1:0];
				REG_NEAR_KP:          gains_q.near_kp          <= cfg_data[GAIN_W-1:0];
				REG_NEAR_KD:          gains_q.near_kd          <= cfg_data[GAIN_W-1:0];
				REG_APPROACH_DIST_SQ: gains_q.approach_dist_sq <= cfg_data[DIST_W-1:0];
				REG_ARRIVE_DIST_SQ:   gains_q.arrive_dist_sq   <= cfg_data[DIST_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign waypoint_lat = waypoint_lat_q;
	assign waypoint_lon = waypoint_lon_q;
	assign gains        = gains_q;

endmodule

`default_nettype wire

FILE: src/wpg_error.sv
// wpg_error: position error against the waypoint, axis saturation, magnitudes
// and height error, registered into stage 2; depends on wpg_pkg
`default_nettype none

module wpg_error #(
	parameter int COORD_BITS = wpg_pkg::DEFAULT_COORD_BITS
) (
	input  wire logic                                 clk,
	input  wire logic                                 load,
	input  wire logic signed [COORD_BITS-2:0]         cur_lat,
	input  wire logic signed [COORD_BITS-1:0]         cur_lon,
	input  wire logic signed [COORD_BITS-2:0]         waypoint_lat,
	input  wire logic signed [COORD_BITS-1:0]         waypoint_lon,
	input  wire logic signed [wpg_pkg::HEIGHT_W-1:0]  height_goal,
	input  wire logic signed [wpg_pkg::HEIGHT_W-1:0]  height_now,
	output logic signed [wpg_pkg::CMD_W-1:0]          dlat_s2,
	output logic signed [wpg_pkg::CMD_W-1:0]          dlon_s2,
	output logic [wpg_pkg::CMD_W-1:0]                 mlat_s2,
	output logic [wpg_pkg::CMD_W-1:0]                 mlon_s2,
	output logic                                      huge_s2,
	output logic signed [wpg_pkg::THRUST_W-1:0]       thrust_s2
);
	import wpg_pkg::*;

	localparam int LAT_W = COORD_BITS - 1;
	localparam int LON_W = COORD_BITS;
	localparam int ERR_W = (COORD_BITS + 1 > CMD_W + 2) ? COORD_BITS + 1 : CMD_W + 2;

	localparam logic signed [ERR_W-1:0] ERR_POS = {{(ERR_W-CMD_W){1'b0}}, 1'b1, {(CMD_W-1){1'b0}}};
	localparam logic signed [ERR_W-1:0] ERR_NEG = -ERR_POS;
	localparam logic signed [ERR_W-1:0] ERR_MAX = ERR_POS - 1;

	function automatic logic signed [CMD_W-1:0] sat_err(input logic signed [ERR_W-1:0] x);
		logic signed [CMD_W-1:0] r;
		if (x > ERR_MAX) begin
			r = ERR_MAX[CMD_W-1:0];
		end else if (x < ERR_NEG) begin
			r = ERR_NEG[CMD_W-1:0];
		end else begin
			r = x[CMD_W-1:0];
		end
		return r;
	endfunction

	// magnitude is only meaningful when the error is within +-2^31
	function automatic logic [CMD_W-1:0] mag_err(input logic signed [ERR_W-1:0] x);
		logic signed [ERR_W-1:0] n;
		n = -x;
		return x[ERR_W-1] ? n[CMD_W-1:0] : x[CMD_W-1:0];
	endfunction

	logic signed [ERR_W-1:0]    raw_lat;
	logic signed [ERR_W-1:0]    raw_lon;
	logic                       huge;
	logic signed [THRUST_W-1:0] thrust;

	assign raw_lat = {{(ERR_W-LAT_W){cur_lat[LAT_W-1]}}, cur_lat}
		- {{(ERR_W-LAT_W){waypoint_lat[LAT_W-1]}}, waypoint_lat};
	assign raw_lon = {{(ERR_W-LON_W){cur_lon[LON_W-1]}}, cur_lon}
		- {{(ERR_W-LON_W){waypoint_lon[LON_W-1]}}, waypoint_lon};

	assign huge = (raw_lat > ERR_POS) || (raw_lat < ERR_NEG)
		|| (raw_lon > ERR_POS) || (raw_lon < ERR_NEG);

	assign thrust = {height_goal[HEIGHT_W-1], height_goal}
		- {height_now[HEIGHT_W-1], height_now};

	always_ff @(posedge clk) begin
		if (load) begin
			dlat_s2   <= sat_err(raw_lat);
			dlon_s2   <= sat_err(raw_lon);
			mlat_s2   <= mag_err(raw_lat);
			mlon_s2   <= mag_err(raw_lon);
			huge_s2   <= huge;
			thrust_s2 <= thrust;
		end
	end

endmodule

`default_nettype wire

FILE: src/wpg_mult.sv
// wpg_mult: squared errors and the gain products of both modes, registered
// into stage 3; depends on wpg_pkg
`default_nettype none

module wpg_mult (
	input  wire logic                                clk,
	input  wire logic                                load,
	input  wire wpg_pkg::gain_cfg_t                  gains,
	input  wire logic signed [wpg_pkg::CMD_W-1:0]    dlat_s2,
	input  wire logic signed [wpg_pkg::CMD_W-1:0]    dlon_s2,
	input  wire logic [wpg_pkg::CMD_W-1:0]           mlat_s2,
	input  wire logic [wpg_pkg::CMD_W-1:0]           mlon_s2,
	input  wire logic                                huge_s2,
	input  wire logic signed [wpg_pkg::VEL_W-1:0]    vel_north_s2,
	input  wire logic signed [wpg_pkg::VEL_W-1:0]    vel_east_s2,
	input  wire logic signed [wpg_pkg::THRUST_W-1:0] thrust_s2,
	output logic [wpg_pkg::SQ_W-1:0]                 sq_lat_s3,
	output logic [wpg_pkg::SQ_W-1:0]                 sq_lon_s3,
	output logic signed [wpg_pkg::SUM_W-1:0]         far_a_s3,
	output logic signed [wpg_pkg::SUM_W-1:0]         far_b_s3,
	output logic signed [wpg_pkg::SUM_W-1:0]         near_a_s3,
	output logic signed [wpg_pkg::SUM_W-1:0]         near_b_s3,
	output logic                                     huge_s3,
	output logic signed [wpg_pkg::THRUST_W-1:0]      thrust_s3
);
	import wpg_pkg::*;

	logic signed [GAIN_W:0] kpf, kdf, kpn, kdn;
	logic signed [SUM_W-1:0] pf_lon, pf_lat, pn_lat, pn_lon;
	logic signed [SUM_W-1:0] df_ve, df_vn, dn_vn, dn_ve;
	logic [SQ_W-1:0] sq_lat, sq_lon;

	assign kpf = $signed({1'b0, gains.far_kp});
	assign kdf = $signed({1'b0, gains.far_kd});
	assign kpn = $signed({1'b0, gains.near_kp});
	assign kdn = $signed({1'b0, gains.near_kd});

	assign pf_lon = kpf * dlon_s2;
	assign pf_lat = kpf * dlat_s2;
	assign pn_lat = kpn * dlat_s2;
	assign pn_lon = kpn * dlon_s2;
	assign df_ve  = kdf * vel_east_s2;
	assign df_vn  = kdf * vel_north_s2;
	assign dn_vn  = kdn * vel_north_s2;
	assign dn_ve  = kdn * vel_east_s2;

	assign sq_lat = mlat_s2 * mlat_s2;
	assign sq_lon = mlon_s2 * mlon_s2;

	// far roll uses -(a), far pitch uses +(b); near uses -(a) and -(b)
	always_ff @(posedge clk) begin
		if (load) begin
			sq_lat_s3 <= sq_lat;
			sq_lon_s3 <= sq_lon;
			far_a_s3  <= pf_lon + df_ve;
			far_b_s3  <= pf_lat + df_vn;
			near_a_s3 <= pn_lat + dn_vn;
			near_b_s3 <= pn_lon + dn_ve;
			huge_s3   <= huge_s2;
			thrust_s3 <= thrust_s2;
		end
	end

endmodule

`default_nettype wire

FILE: src/wpg_law.sv
// wpg_law: mode decision on the squared error, sign selection, rounding and
// saturation into the result register; depends on wpg_pkg
`default_nettype none

module wpg_law #(
	parameter int GAIN_FRAC_BITS = wpg_pkg::DEFAULT_GAIN_FRAC_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                load,
	input  wire wpg_pkg::gain_cfg_t                  gains,
	input  wire logic [wpg_pkg::SQ_W-1:0]            sq_lat_s3,
	input  wire logic [wpg_pkg::SQ_W-1:0]            sq_lon_s3,
	input  wire logic signed [wpg_pkg::SUM_W-1:0]    far_a_s3,
	input  wire logic signed [wpg_pkg::SUM_W-1:0]    far_b_s3,
	input  wire logic signed [wpg_pkg::SUM_W-1:0]    near_a_s3,
	input  wire logic signed [wpg_pkg::SUM_W-1:0]    near_b_s3,
	input  wire logic                                huge_s3,
	input  wire logic signed [wpg_pkg::THRUST_W-1:0] thrust_s3,
	output logic signed [wpg_pkg::CMD_W-1:0]         roll_q,
	output logic signed [wpg_pkg::CMD_W-1:0]         pitch_q,
	output logic signed [wpg_pkg::THRUST_W-1:0]      thrust_q,
	output logic                                     velocity_mode_q,
	output logic                                     arrived_q
);
	import wpg_pkg::*;

	localparam logic signed [CMD_PRE_W-1:0] HALF =
		{{(CMD_PRE_W-1){1'b0}}, 1'b1} <<< (GAIN_FRAC_BITS - 1);

	function automatic logic signed [CMD_PRE_W-1:0] ext(input logic signed [SUM_W-1:0] v);
		return {{(CMD_PRE_W-SUM_W){v[SUM_W-1]}}, v};
	endfunction

	// round half up, then saturate
	function automatic logic signed [CMD_W-1:0] scale(input logic signed [CMD_PRE_W-1:0] y);
		logic signed [CMD_PRE_W-1:0] t;
		t = y + HALF;
		return sat_cmd(t >>> GAIN_FRAC_BITS);
	endfunction

	logic [SQ_W-1:0]             sq;
	logic                        near, arr;
	logic signed [CMD_PRE_W-1:0] roll_y, pitch_y;

	assign sq   = sq_lat_s3 + sq_lon_s3;
	assign near = !huge_s3 && (sq < {{(SQ_W-DIST_W){1'b0}}, gains.approach_dist_sq});
	assign arr  = near && (sq < {{(SQ_W-DIST_W){1'b0}}, gains.arrive_dist_sq});

	assign roll_y  = near ? -ext(near_a_s3) : -ext(far_a_s3);
	assign pitch_y = near ? -ext(near_b_s3) : ext(far_b_s3);

	always_ff @(posedge clk) begin
		if (load) begin
			roll_q          <= scale(roll_y);
			pitch_q         <= scale(pitch_y);
			thrust_q        <= thrust_s3;
			velocity_mode_q <= near;
			arrived_q       <= arr;
		end
	end

endmodule

`default_nettype wire

FILE: src/waypoint_pd_guidance.sv
// waypoint_pd_guidance: top level, input register, stage valids and handshake
// depends on wpg_pkg, wpg_cfg_regs, wpg_error, wpg_mult, wpg_law
`default_nettype none

// Two-mode PD guidance toward a configured waypoint. Each sample beat gives
// position in nanoradians, velocity and heights; one command beat comes out
// per sample, in order, after the error stage, multiplier stage and result
// register behind the input register. A new sample can be taken every cycle
// while sample_stall is low; each stage holds only while the stage after it
// is full and held, so bubbles are filled even while a finished command waits.
// Far from the waypoint the block gives attitude commands; once the squared
// error is below approach_dist_sq it switches to velocity commands and flags
// arrival below arrive_dist_sq. Write the configuration registers only while
// no sample is in flight.
module waypoint_pd_guidance #(
	parameter int COORD_BITS     = wpg_pkg::DEFAULT_COORD_BITS,
	parameter int GAIN_FRAC_BITS = wpg_pkg::DEFAULT_GAIN_FRAC_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [wpg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [((COORD_BITS > wpg_pkg::DIST_W) ? COORD_BITS : wpg_pkg::DIST_W)-1:0]
	                                                 cfg_data,
	input  wire logic                                sample_valid,
	output logic                                     sample_stall,
	input  wire logic signed [COORD_BITS-2:0]        cur_lat,
	input  wire logic signed [COORD_BITS-1:0]        cur_lon,
	input  wire logic signed [wpg_pkg::VEL_W-1:0]    vel_north,
	input  wire logic signed [wpg_pkg::VEL_W-1:0]    vel_east,
	input  wire logic signed [wpg_pkg::HEIGHT_W-1:0] height_goal,
	input  wire logic signed [wpg_pkg::HEIGHT_W-1:0] height_now,
	output logic                                     cmd_valid,
	input  wire logic                                cmd_stall,
	output logic signed [wpg_pkg::CMD_W-1:0]         roll_cmd,
	output logic signed [wpg_pkg::CMD_W-1:0]         pitch_cmd,
	output logic signed [wpg_pkg::THRUST_W-1:0]      thrust_cmd,
	output logic                                     velocity_mode,
	output logic                                     arrived
);
	import wpg_pkg::*;

	localparam int CFG_DATA_W = (COORD_BITS > DIST_W) ? COORD_BITS : DIST_W;

	logic signed [COORD_BITS-2:0] waypoint_lat;
	logic signed [COORD_BITS-1:0] waypoint_lon;
	gain_cfg_t                    gains;

	logic valid_s1, valid_s2, valid_s3, valid_q;
	logic ready_s1, ready_s2, ready_s3, ready_out;

	logic signed [COORD_BITS-2:0] cur_lat_s1;
	logic signed [COORD_BITS-1:0] cur_lon_s1;
	logic signed [VEL_W-1:0]      vel_north_s1, vel_east_s1, vel_north_s2, vel_east_s2;
	logic signed [HEIGHT_W-1:0]   height_goal_s1, height_now_s1;

	logic signed [CMD_W-1:0]    dlat_s2, dlon_s2;
	logic [CMD_W-1:0]           mlat_s2, mlon_s2;
	logic                       huge_s2, huge_s3;
	logic signed [THRUST_W-1:0] thrust_s2, thrust_s3;
	logic [SQ_W-1:0]            sq_lat_s3, sq_lon_s3;
	logic signed [SUM_W-1:0]    far_a_s3, far_b_s3, near_a_s3, near_b_s3;

	// a stage may load when it is empty or its content moves on
	assign ready_out    = !valid_q || !cmd_stall;
	assign ready_s3     = !valid_s3 || ready_out;
	assign ready_s2     = !valid_s2 || ready_s3;
	assign ready_s1     = !valid_s1 || ready_s2;
	assign sample_stall = !ready_s1;
	assign cmd_valid    = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= sample_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
			if (ready_out) begin
				valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			cur_lat_s1     <= cur_lat;
			cur_lon_s1     <= cur_lon;
			vel_north_s1   <= vel_north;
			vel_east_s1    <= vel_east;
			height_goal_s1 <= height_goal;
			height_now_s1  <= height_now;
		end
		if (ready_s2) begin
			vel_north_s2 <= vel_north_s1;
			vel_east_s2  <= vel_east_s1;
		end
	end

	wpg_cfg_regs #(
		.COORD_BITS (COORD_BITS),
		.DATA_W     (CFG_DATA_W)
	) u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.waypoint_lat (waypoint_lat),
		.waypoint_lon (waypoint_lon),
		.gains        (gains)
	);

	wpg_error #(
		.COORD_BITS (COORD_BITS)
	) u_error (
		.clk          (clk),
		.load         (ready_s2),
		.cur_lat      (cur_lat_s1),
		.cur_lon      (cur_lon_s1),
		.waypoint_lat (waypoint_lat),
		.waypoint_lon (waypoint_lon),
		.height_goal  (height_goal_s1),
		.height_now   (height_now_s1),
		.dlat_s2      (dlat_s2),
		.dlon_s2      (dlon_s2),
		.mlat_s2      (mlat_s2),
		.mlon_s2      (mlon_s2),
		.huge_s2      (huge_s2),
		.thrust_s2    (thrust_s2)
	);

	wpg_mult u_mult (
		.clk          (clk),
		.load         (ready_s3),
		.gains        (gains),
		.dlat_s2      (dlat_s2),
		.dlon_s2      (dlon_s2),
		.mlat_s2      (mlat_s2),
		.mlon_s2      (mlon_s2),
		.huge_s2      (huge_s2),
		.vel_north_s2 (vel_north_s2),
		.vel_east_s2  (vel_east_s2),
		.thrust_s2    (thrust_s2),
		.sq_lat_s3    (sq_lat_s3),
		.sq_lon_s3    (sq_lon_s3),
		.far_a_s3     (far_a_s3),
		.far_b_s3     (far_b_s3),
		.near_a_s3    (near_a_s3),
		.near_b_s3    (near_b_s3),
		.huge_s3      (huge_s3),
		.thrust_s3    (thrust_s3)
	);

	wpg_law #(
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_law (
		.clk             (clk),
		.load            (ready_out),
		.gains           (gains),
		.sq_lat_s3       (sq_lat_s3),
		.sq_lon_s3       (sq_lon_s3),
		.far_a_s3        (far_a_s3),
		.far_b_s3        (far_b_s3),
		.near_a_s3       (near_a_s3),
		.near_b_s3       (near_b_s3),
		.huge_s3         (huge_s3),
		.thrust_s3       (thrust_s3),
		.roll_q          (roll_cmd),
		.pitch_q         (pitch_cmd),
		.thrust_q        (thrust_cmd),
		.velocity_mode_q (velocity_mode),
		.arrived_q       (arrived)
	);

endmodule

`default_nettype wire

FILE: src/wpg_checker.sv
// wpg_checker: port-level assertions for waypoint_pd_guidance, bound to the top
// depends on wpg_pkg and waypoint_pd_guidance
`default_nettype none

module wpg_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                sample_valid,
	input wire logic                                sample_stall,
	input wire logic                                cmd_valid,
	input wire logic                                cmd_stall,
	input wire logic signed [wpg_pkg::CMD_W-1:0]    roll_cmd,
	input wire logic signed [wpg_pkg::CMD_W-1:0]    pitch_cmd,
	input wire logic signed [wpg_pkg::THRUST_W-1:0] thrust_cmd,
	input wire logic                                velocity_mode,
	input wire logic                                arrived
);

	// a held command beat keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_stall |=> cmd_valid && $stable(roll_cmd) && $stable(pitch_cmd)
			&& $stable(thrust_cmd) && $stable(velocity_mode) && $stable(arrived))
		else $error("stalled command beat changed");

	// arrival is only flagged in velocity mode
	a_arrive: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && arrived |-> velocity_mode)
		else $error("arrived without velocity mode");

	// with an empty result register the pipeline can always move
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_valid |-> !sample_stall)
		else $error("sample stalled while result register empty");

	// an accepted sample reaches the output when the receiver does not stall in between
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall) ##1 !cmd_stall ##1 !cmd_stall ##1 !cmd_stall
			|=> cmd_valid)
		else $error("command beat missing after pipeline latency");

endmodule

bind waypoint_pd_guidance wpg_checker u_wpg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.sample_valid  (sample_valid),
	.sample_stall  (sample_stall),
	.cmd_valid     (cmd_valid),
	.cmd_stall     (cmd_stall),
	.roll_cmd      (roll_cmd),
	.pitch_cmd     (pitch_cmd),
	.thrust_cmd    (thrust_cmd),
	.velocity_mode (velocity_mode),
	.arrived       (arrived)
);

`default_nettype wire

FILE: tb/sv/tb_waypoint_pd_guidance.sv
// tb_waypoint_pd_guidance: self-checking testbench for the two-mode waypoint guidance block
// holds its own command predictor, a queue of expected command beats and a result checker
// depends on wpg_pkg and waypoint_pd_guidance
`timescale 1ns / 1ps

module tb_waypoint_pd_guidance;

	import wpg_pkg::*;

	localparam int COORD = DEFAULT_COORD_BITS;
	localparam int FRAC  = DEFAULT_GAIN_FRAC_BITS;
	localparam int CFG_W = (COORD > DIST_W) ? COORD : DIST_W;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 12;

	localparam longint          CMD_MAX = 64'sd2147483647;
	localparam longint          CMD_MIN = -64'sd2147483648;
	localparam longint unsigned ERR_LIM = 64'h0000_0000_8000_0000;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
	localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};

	typedef struct packed {
		logic signed [COORD-2:0]    lat;
		logic signed [COORD-1:0]    lon;
		logic signed [VEL_W-1:0]    vn;
		logic signed [VEL_W-1:0]    ve;
		logic signed [HEIGHT_W-1:0] hg;
		logic signed [HEIGHT_W-1:0] hn;
	} nav_sample_t;

	typedef struct packed {
		logic [CMD_W-1:0]    roll;
		logic [CMD_W-1:0]    pitch;
		logic [THRUST_W-1:0] thrust;
		logic                vmode;
		logic                arr;
	} guidance_cmd_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]       cfg_data;
	logic                   sample_valid;
	logic                   sample_stall;
	logic signed [COORD-2:0]    cur_lat;
	logic signed [COORD-1:0]    cur_lon;
	logic signed [VEL_W-1:0]    vel_north;
	logic signed [VEL_W-1:0]    vel_east;
	logic signed [HEIGHT_W-1:0] height_goal;
	logic signed [HEIGHT_W-1:0] height_now;
	logic                   cmd_valid;
	logic                   cmd_stall = 1'b0;
	logic signed [CMD_W-1:0]    roll_cmd;
	logic signed [CMD_W-1:0]    pitch_cmd;
	logic signed [THRUST_W-1:0] thrust_cmd;
	logic                   velocity_mode;
	logic                   arrived;

	// predictor copy of the register file
	logic signed [COORD-2:0] wp_lat;
	logic signed [COORD-1:0] wp_lon;
	logic [GAIN_W-1:0]       far_kp, far_kd, near_kp, near_kd;
	logic [DIST_W-1:0]       approach_sq, arrive_sq;

	guidance_cmd_t cmd_expect_q[$];
	int            fail_count  = 0;
	int            cycle_count = 0;
	bit            tx_idle_en  = 1'b1;
	bit            rx_idle_en  = 1'b1;
	int            hold_left   = 0;
	int            rx_burst    = 0;

	waypoint_pd_guidance u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.cur_lat      (cur_lat),
		.cur_lon      (cur_lon),
		.vel_north    (vel_north),
		.vel_east     (vel_east),
		.height_goal  (height_goal),
		.height_now   (height_now),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.roll_cmd     (roll_cmd),
		.pitch_cmd    (pitch_cmd),
		.thrust_cmd   (thrust_cmd),
		.velocity_mode(velocity_mode),
		.arrived      (arrived)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ---------------------------------------------------------------- predictor

	function automatic longint sat_err(longint x);
		if (x > CMD_MAX) begin
			return CMD_MAX;
		end else if (x < CMD_MIN) begin
			return CMD_MIN;
		end
		return x;
	endfunction

	// round half up by 2^FRAC, then clamp to 32 bits
	function automatic logic [CMD_W-1:0] round_scale(longint acc);
		longint q;
		q = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
		q = sat_err(q);
		return q[CMD_W-1:0];
	endfunction

	function automatic guidance_cmd_t predict_cmd(nav_sample_t s);
		guidance_cmd_t   c;
		longint          raw_lat, raw_lon, dlat, dlon, vn, ve, kp, kd, dh;
		longint unsigned mlat, mlon, sq;
		logic            near_f, arr_f;
		raw_lat = longint'($signed(s.lat)) - longint'(wp_lat);
		raw_lon = longint'($signed(s.lon)) - longint'(wp_lon);
		vn      = longint'($signed(s.vn));
		ve      = longint'($signed(s.ve));
		dh      = longint'($signed(s.hg)) - longint'($signed(s.hn));
		dlat    = sat_err(raw_lat);
		dlon    = sat_err(raw_lon);
		mlat    = (raw_lat < 0) ? -raw_lat : raw_lat;
		mlon    = (raw_lon < 0) ? -raw_lon : raw_lon;
		near_f  = 1'b0;
		arr_f   = 1'b0;
		// an error beyond 2^31 on either axis never counts as near
		if (mlat <= ERR_LIM && mlon <= ERR_LIM) begin
			sq     = mlat * mlat + mlon * mlon;
			near_f = sq < {2'b00, approach_sq};
			arr_f  = near_f && (sq < {2'b00, arrive_sq});
		end
		if (near_f) begin
			kp      = longint'(near_kp);
			kd      = longint'(near_kd);
			c.roll  = round_scale(-(kp * dlat) - kd * vn);
			c.pitch = round_scale(-(kp * dlon) - kd * ve);
		end else begin
			kp      = longint'(far_kp);
			kd      = longint'(far_kd);
			c.roll  = round_scale(-(kp * dlon) - kd * ve);
			c.pitch = round_scale(kp * dlat + kd * vn);
		end
		c.thrust = dh[THRUST_W-1:0];
		c.vmode  = near_f;
		c.arr    = arr_f;
		return c;
	endfunction

	// ---------------------------------------------------------------- checker

	always @(posedge clk) begin
		guidance_cmd_t e;
		if (arst_n && cmd_valid && !cmd_stall) begin
			if (cmd_expect_q.size() == 0) begin
				$error("command beat with nothing expected");
				fail_count++;
			end else begin
				e = cmd_expect_q.pop_front();
				if (roll_cmd !== e.roll) begin
					$error("roll_cmd expected %0d actual %0d", $signed(e.roll), roll_cmd);
					fail_count++;
				end
				if (pitch_cmd !== e.pitch) begin
					$error("pitch_cmd expected %0d actual %0d", $signed(e.pitch), pitch_cmd);
					fail_count++;
				end
				if (thrust_cmd !== e.thrust) begin
					$error("thrust_cmd expected %0d actual %0d", $signed(e.thrust), thrust_cmd);
					fail_count++;
				end
				if (velocity_mode !== e.vmode) begin
					$error("velocity_mode expected %0d actual %0d", e.vmode, velocity_mode);
					fail_count++;
				end
				if (arrived !== e.arr) begin
					$error("arrived expected %0d actual %0d", e.arr, arrived);
					fail_count++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- receiver stalls

	always @(negedge clk) begin
		if (hold_left > 0) begin
			cmd_stall <= 1'b1;
			hold_left--;
		end else if (rx_burst > 0) begin
			cmd_stall <= 1'b1;
			rx_burst--;
		end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
			rx_burst  = $urandom_range(0, 4);
			cmd_stall <= 1'b1;
		end else begin
			cmd_stall <= 1'b0;
		end
	end

	// ---------------------------------------------------------------- shared tasks

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_WAYPOINT_LAT:     wp_lat      = data[COORD-2:0];
			REG_WAYPOINT_LON:     wp_lon      = data[COORD-1:0];
			REG_FAR_KP:           far_kp      = data[GAIN_W-1:0];
			REG_FAR_KD:           far_kd      = data[GAIN_W-1:0];
			REG_NEAR_KP:          near_kp     = data[GAIN_W-1:0];
			REG_NEAR_KD:          near_kd     = data[GAIN_W-1:0];
			REG_APPROACH_DIST_SQ: approach_sq = data[DIST_W-1:0];
			REG_ARRIVE_DIST_SQ:   arrive_sq   = data[DIST_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic program_all(logic [CFG_W-1:0] lat_d, logic [CFG_W-1:0] lon_d,
			logic [CFG_W-1:0] fkp, logic [CFG_W-1:0] fkd, logic [CFG_W-1:0] nkp,
			logic [CFG_W-1:0] nkd, logic [CFG_W-1:0] app, logic [CFG_W-1:0] arr);
		write_reg(REG_WAYPOINT_LAT, lat_d);
		write_reg(REG_WAYPOINT_LON, lon_d);
		write_reg(REG_FAR_KP, fkp);
		write_reg(REG_FAR_KD, fkd);
		write_reg(REG_NEAR_KP, nkp);
		write_reg(REG_NEAR_KD, nkd);
		write_reg(REG_APPROACH_DIST_SQ, app);
		write_reg(REG_ARRIVE_DIST_SQ, arr);
	endtask

	task automatic send_sample(nav_sample_t s);
		int            gap;
		guidance_cmd_t e;
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			@(negedge clk);
			sample_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		e = predict_cmd(s);
		@(negedge clk);
		sample_valid <= 1'b1;
		cur_lat      <= s.lat;
		cur_lon      <= s.lon;
		vel_north    <= s.vn;
		vel_east     <= s.ve;
		height_goal  <= s.hg;
		height_now   <= s.hn;
		do @(posedge clk); while (sample_stall);
		cmd_expect_q.push_back(e);
	endtask

	task automatic send_nav(longint lat, longint lon, longint vn, longint ve,
			longint hg, longint hn);
		nav_sample_t s;
		s.lat = lat[COORD-2:0];
		s.lon = lon[COORD-1:0];
		s.vn  = vn[VEL_W-1:0];
		s.ve  = ve[VEL_W-1:0];
		s.hg  = hg[HEIGHT_W-1:0];
		s.hn  = hn[HEIGHT_W-1:0];
		send_sample(s);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (cmd_expect_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// mostly offsets around the waypoint so both modes and arrival get hit
	function automatic longint rand_offset();
		int m;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: m = 40;
			4, 5, 6:    m = 800;
			7, 8:       m = 100000;
			default:    return longint'({$urandom(), $urandom()});
		endcase
		return longint'($urandom_range(0, 2 * m)) - longint'(m);
	endfunction

	function automatic nav_sample_t rand_sample();
		nav_sample_t s;
		longint      p;
		s.vn = VEL_W'($urandom());
		s.ve = VEL_W'($urandom());
		s.hg = HEIGHT_W'($urandom());
		s.hn = HEIGHT_W'($urandom());
		if ($urandom_range(0, 4) == 0) begin
			s.lat = $urandom();
			s.lon = COORD'({$urandom(), $urandom()});
		end else begin
			p     = longint'(wp_lat) + rand_offset();
			s.lat = p[COORD-2:0];
			p     = longint'(wp_lon) + rand_offset();
			s.lon = p[COORD-1:0];
		end
		return s;
	endfunction

	function automatic logic [CFG_W-1:0] rand_gain();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return CFG_W'(GAIN_MAX);
			default: return CFG_W'({$urandom(), $urandom()});
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] rand_dist();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return DIST_MAX;
			2:       return r[CFG_W-1:0];
			default: return r[CFG_W-1:0] >> $urandom_range(22, 58);
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] rand_coord();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		if ($urandom_range(0, 1) == 0) begin
			return r[CFG_W-1:0];
		end
		return CFG_W'(longint'($urandom_range(0, 2000000000)) - 64'sd1000000000);
	endfunction

	// ---------------------------------------------------------------- tests

	task automatic test_reset_values();
		// waypoint at origin, thresholds 250000 and 1111
		send_nav(0, 0, 0, 0, 0, 0);
		send_nav(33, 0, 100, -100, 5, 7);
		send_nav(0, -34, -1, 1, -5, 9);
		send_nav(300, 400, 0, 0, 0, 0);
		send_nav(299, 400, 3, 4, 0, 0);
		send_nav(-299, -400, -32768, 32767, 1048575, -1048576);
		send_nav(5000, -7000, 32767, -32768, -1048576, 1048575);
		// error beyond 2^31 on the longitude axis only
		send_nav(64'sh7FFF_FFFF, -64'sh1_0000_0000, 12, -12, 0, 0);
		send_nav(-64'sh8000_0000, 64'sh0_FFFF_FFFF, -32768, -32768, 1, -1);
		wait_drained();
	endtask

	task automatic test_register_extremes();
		// upper data bits must be masked off: waypoint becomes -2^31 and -1
		program_all({CFG_W{1'b1}} ^ CFG_W'(64'h7FFF_FFFF), {CFG_W{1'b1}},
			CFG_W'(GAIN_MAX), CFG_W'(GAIN_MAX), CFG_W'(GAIN_MAX), CFG_W'(GAIN_MAX),
			DIST_MAX, DIST_MAX);
		send_nav(-64'sh8000_0000, -1, 32767, -32768, 0, 0);
		send_nav(0, -1, -32768, 32767, 0, 0);
		send_nav(64'sh7FFF_FFFF, -64'sh1_0000_0000, 32767, 32767, 0, 0);
		send_nav(-64'sh7FFF_0000, 64'sh0_FFFF_FFFF, -32768, -32768, 0, 0);
		wait_drained();
		program_all('0, '0, '0, '0, '0, '0, '0, '0);
		send_nav(0, 0, 32767, -32768, 77, -77);
		send_nav(123456, -654321, -32768, 32767, 0, 0);
		wait_drained();
		// rounding ties toward plus infinity with a gain of one lsb
		program_all('0, '0, CFG_W'(1), '0, CFG_W'(1), '0, '0, '0);
		send_nav(128, 0, 0, 0, 0, 0);
		send_nav(-128, 0, 0, 0, 0, 0);
		send_nav(-129, 127, 0, 0, 0, 0);
		send_nav(127, -129, 0, 0, 0, 0);
		wait_drained();
	endtask

	task automatic test_random_settings(int n_settings, int n_items);
		for (int k = 0; k < n_settings; k++) begin
			program_all(rand_coord(), rand_coord(), rand_gain(), rand_gain(),
				rand_gain(), rand_gain(), rand_dist(), rand_dist());
			for (int i = 0; i < n_items; i++) begin
				send_sample(rand_sample());
			end
			wait_drained();
		end
	endtask

	task automatic test_backpressure();
		program_all(rand_coord(), rand_coord(), rand_gain(), rand_gain(),
			rand_gain(), rand_gain(), 62'd1 << 40, 62'd1 << 20);
		tx_idle_en = 1'b0;
		// receiver holds off long enough for the pipe to fill and stall the input
		hold_left  = 300;
		for (int i = 0; i < 80; i++) begin
			send_sample(rand_sample());
		end
		wait_drained();
		tx_idle_en = 1'b1;
	endtask

	task automatic test_full_rate();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		program_all(rand_coord(), rand_coord(), rand_gain(), rand_gain(),
			rand_gain(), rand_gain(), 62'd1 << 34, 62'd1 << 14);
		for (int i = 0; i < 250; i++) begin
			send_sample(rand_sample());
		end
		wait_drained();
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		sample_valid = 1'b0;
		cur_lat      = '0;
		cur_lon      = '0;
		vel_north    = '0;
		vel_east     = '0;
		height_goal  = '0;
		height_now   = '0;
		wp_lat       = '0;
		wp_lon       = '0;
		far_kp       = RST_FAR_KP;
		far_kd       = RST_FAR_KD;
		near_kp      = RST_NEAR_KP;
		near_kd      = RST_NEAR_KD;
		approach_sq  = RST_APPROACH_DIST_SQ;
		arrive_sq    = RST_ARRIVE_DIST_SQ;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_values();
		test_register_extremes();
		test_random_settings(7, 220);
		test_backpressure();
		test_full_rate();

		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
